// ----- hw/rtl/vng_pkg.sv -----
// Shared types, constants and helpers for the voxel neighbourhood generator.
// No dependencies; imported by vng_offset_chk, the top level and the testbench.
package vng_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int LEVEL_W        = 7;
  localparam int SIZE_W         = 11;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 11;

  localparam logic [LEVEL_W-1:0] LEVEL_RST = 7'd26;
  localparam logic [SIZE_W-1:0]  SIZE_RST  = 11'd256;

  // command codes carried by in_func
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  // per-axis digit of the 5x5x5 offset cube, 0..4 standing for -2..+2
  localparam logic [2:0] DIG_LAST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL  = 2'd0,
    REG_SIZE_X = 2'd1,
    REG_SIZE_Y = 2'd2,
    REG_SIZE_Z = 2'd3
  } vng_reg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [SIZE_W-1:0]  size_z;
  } vng_cfg_t;

  typedef struct packed {
    logic [2:0] z;
    logic [2:0] y;
    logic [2:0] x;
  } vng_dig_t;

  typedef struct packed {
    logic       ok;     // recognised level
    logic       wide;   // cube range 2 rather than 1
    logic [2:0] limit;  // Manhattan limit
    logic       axis2;  // level 32: axis offsets at distance two too
  } vng_lvl_t;

  function automatic vng_lvl_t level_decode(input logic [LEVEL_W-1:0] lvl);
    vng_lvl_t r;
    r = '0;
    unique case (lvl)
      7'd6:    r = '{ok: 1'b1, wide: 1'b0, limit: 3'd1, axis2: 1'b0};
      7'd18:   r = '{ok: 1'b1, wide: 1'b0, limit: 3'd2, axis2: 1'b0};
      7'd26:   r = '{ok: 1'b1, wide: 1'b0, limit: 3'd3, axis2: 1'b0};
      7'd32:   r = '{ok: 1'b1, wide: 1'b0, limit: 3'd3, axis2: 1'b1};
      7'd56:   r = '{ok: 1'b1, wide: 1'b1, limit: 3'd3, axis2: 1'b0};
      7'd92:   r = '{ok: 1'b1, wide: 1'b1, limit: 3'd4, axis2: 1'b0};
      7'd116:  r = '{ok: 1'b1, wide: 1'b1, limit: 3'd5, axis2: 1'b0};
      7'd124:  r = '{ok: 1'b1, wide: 1'b1, limit: 3'd6, axis2: 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

  // magnitude of the offset encoded by a digit
  function automatic logic [1:0] dig_abs(input logic [2:0] d);
    logic [1:0] r;
    unique case (d)
      3'd0, 3'd4: r = 2'd2;
      3'd1, 3'd3: r = 2'd1;
      default:    r = 2'd0;
    endcase
    return r;
  endfunction

  // next offset in ascending z, y, x order
  function automatic vng_dig_t dig_inc(input vng_dig_t d);
    vng_dig_t r;
    r = d;
    if (d.x != DIG_LAST) begin
      r.x = d.x + 3'd1;
    end else begin
      r.x = 3'd0;
      if (d.y != DIG_LAST) begin
        r.y = d.y + 3'd1;
      end else begin
        r.y = 3'd0;
        r.z = d.z + 3'd1;
      end
    end
    return r;
  endfunction

  function automatic logic dig_end(input vng_dig_t d);
    return (d.x == DIG_LAST) && (d.y == DIG_LAST) && (d.z == DIG_LAST);
  endfunction

endpackage

// ----- hw/rtl/vng_offset_chk.sv -----
// Offset test unit: decides whether one cube offset is a neighbour of the
// centre for the current level and volume. Depends on vng_pkg.
module vng_offset_chk #(
  parameter int COORD_BITS = vng_pkg::COORD_BITS_DEF
) (
  input  vng_pkg::vng_cfg_t       cfg,
  input  logic [COORD_BITS-1:0]   centre_x,
  input  logic [COORD_BITS-1:0]   centre_y,
  input  logic [COORD_BITS-1:0]   centre_z,
  input  vng_pkg::vng_dig_t       dig,
  output logic                    ok,
  output logic [COORD_BITS-1:0]   nb_x,
  output logic [COORD_BITS-1:0]   nb_y,
  output logic [COORD_BITS-1:0]   nb_z
);
  import vng_pkg::*;

  localparam int TW = COORD_BITS + 1;
  localparam int EW = (TW > SIZE_W + 1) ? TW : SIZE_W + 1;

  vng_lvl_t   lvl;
  logic [1:0] ax, ay, az;
  logic [2:0] man;
  logic       any2, inc, in_x, in_y, in_z;

  // t = centre + digit, neighbour = t - 2; in bounds when 2 <= t < size + 2
  // and t - 2 fits the coordinate width
  function automatic logic axis_ok(input logic [COORD_BITS-1:0] c,
                                   input logic [2:0] d,
                                   input logic [SIZE_W-1:0] s);
    logic [TW-1:0] t;
    logic [TW-1:0] v;
    logic [EW-1:0] te;
    logic [EW-1:0] se;
    t  = {1'b0, c} + TW'(d);
    v  = t - TW'(2);
    te = EW'(t);
    se = EW'(s) + EW'(2);
    return (t >= TW'(2)) && !v[TW-1] && (te < se);
  endfunction

  function automatic logic [COORD_BITS-1:0] axis_pos(input logic [COORD_BITS-1:0] c,
                                                     input logic [2:0] d);
    logic [TW-1:0] v;
    v = {1'b0, c} + TW'(d) - TW'(2);
    return v[COORD_BITS-1:0];
  endfunction

  always_comb begin
    lvl  = level_decode(cfg.level);
    ax   = dig_abs(dig.x);
    ay   = dig_abs(dig.y);
    az   = dig_abs(dig.z);
    man  = 3'(ax) + 3'(ay) + 3'(az);
    any2 = (ax == 2'd2) || (ay == 2'd2) || (az == 2'd2);
    inc  = (man != 3'd0) && (man <= lvl.limit) && (lvl.wide || !any2);
    if (lvl.axis2 && (man == 3'd2) && any2) begin
      inc = 1'b1;
    end
    in_x = axis_ok(centre_x, dig.x, cfg.size_x);
    in_y = axis_ok(centre_y, dig.y, cfg.size_y);
    in_z = axis_ok(centre_z, dig.z, cfg.size_z);
    ok   = lvl.ok && inc && in_x && in_y && in_z;
    nb_x = axis_pos(centre_x, dig.x);
    nb_y = axis_pos(centre_y, dig.y);
    nb_z = axis_pos(centre_z, dig.z);
  end

endmodule

// ----- hw/rtl/voxel_neighbourhood_generator.sv -----
// Top level of the voxel neighbourhood generator: config registers, scan
// sequencer and result registers. Depends on vng_pkg and vng_offset_chk.
//
// A begin command (func 0) loads a centre and returns its first neighbour;
// each next command (func 1) returns the following one, with out_last on the
// final neighbour. Neighbours come in ascending z, y, x order over the 5x5x5
// offset cube. The sequencer walks the offsets one per cycle through a single
// offset test unit, first to the neighbour to return and then on to the next
// one so that out_last is known; busy is high meanwhile. A result is shown
// for exactly one cycle with out_valid and cannot be held off. A command that
// yields nothing (no neighbour, unknown level, next after the last) gives no
// beat; a next after the last neighbour is absorbed without busy. Registers
// are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
module voxel_neighbourhood_generator #(
  parameter int COORD_BITS = vng_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [vng_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vng_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [COORD_BITS-1:0]         in_centre_x,
  input  logic [COORD_BITS-1:0]         in_centre_y,
  input  logic [COORD_BITS-1:0]         in_centre_z,
  output logic                          out_valid,
  output logic [COORD_BITS-1:0]         out_nb_x,
  output logic [COORD_BITS-1:0]         out_nb_y,
  output logic [COORD_BITS-1:0]         out_nb_z,
  output logic                          out_last
);
  import vng_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_LOOK
  } state_t;

  state_t                state_r;
  vng_cfg_t              cfg_r;
  logic [COORD_BITS-1:0] centre_x_r, centre_y_r, centre_z_r;
  vng_dig_t              scan_r;
  vng_dig_t              cur_r;
  logic                  active_r;
  logic                  out_valid_r;
  logic                  out_last_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r, out_z_r;

  logic                  hit;
  logic                  scan_end;
  logic [COORD_BITS-1:0] nb_x, nb_y, nb_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level  <= LEVEL_RST;
      cfg_r.size_x <= SIZE_RST;
      cfg_r.size_y <= SIZE_RST;
      cfg_r.size_z <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (vng_reg_t'(cfg_index))
        REG_LEVEL:  cfg_r.level  <= cfg_data[LEVEL_W-1:0];
        REG_SIZE_X: cfg_r.size_x <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: cfg_r.size_y <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: cfg_r.size_z <= cfg_data[SIZE_W-1:0];
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  vng_offset_chk #(
    .COORD_BITS(COORD_BITS)
  ) u_chk_unit (
    .cfg      (cfg_r),
    .centre_x (centre_x_r),
    .centre_y (centre_y_r),
    .centre_z (centre_z_r),
    .dig      (scan_r),
    .ok       (hit),
    .nb_x     (nb_x),
    .nb_y     (nb_y),
    .nb_z     (nb_z)
  );

  assign scan_end = dig_end(scan_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      centre_x_r  <= '0;
      centre_y_r  <= '0;
      centre_z_r  <= '0;
      scan_r      <= '0;
      cur_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          out_valid_r <= 1'b0;
          if (start) begin
            if (in_func == FUNC_BEGIN) begin
              centre_x_r <= in_centre_x;
              centre_y_r <= in_centre_y;
              centre_z_r <= in_centre_z;
              scan_r     <= '0;
              active_r   <= 1'b1;
              state_r    <= ST_FIND;
            end else if (active_r) begin
              scan_r  <= cur_r;
              state_r <= ST_FIND;
            end
          end
        end
        // look for the neighbour to return
        ST_FIND: begin
          if (hit) begin
            out_x_r <= nb_x;
            out_y_r <= nb_y;
            out_z_r <= nb_z;
            if (scan_end) begin
              out_last_r  <= 1'b1;
              out_valid_r <= 1'b1;
              active_r    <= 1'b0;
              state_r     <= ST_IDLE;
            end else begin
              out_valid_r <= 1'b0;
              cur_r       <= dig_inc(scan_r);
              scan_r      <= dig_inc(scan_r);
              state_r     <= ST_LOOK;
            end
          end else if (scan_end) begin
            out_valid_r <= 1'b0;
            active_r    <= 1'b0;
            state_r     <= ST_IDLE;
          end else begin
            out_valid_r <= 1'b0;
            scan_r      <= dig_inc(scan_r);
          end
        end
        // look ahead for a further neighbour to settle the last flag
        ST_LOOK: begin
          if (hit) begin
            out_last_r  <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else if (scan_end) begin
            out_last_r  <= 1'b1;
            out_valid_r <= 1'b1;
            active_r    <= 1'b0;
            state_r     <= ST_IDLE;
          end else begin
            out_valid_r <= 1'b0;
            scan_r      <= dig_inc(scan_r);
          end
        end
        default: begin
          out_valid_r <= 1'b0;
          state_r     <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_nb_x  = out_x_r;
  assign out_nb_y  = out_y_r;
  assign out_nb_z  = out_z_r;
  assign out_last  = out_last_r;

endmodule

// ----- hw/rtl/vng_checker.sv -----
// Port-level checks on the voxel neighbourhood generator, bound to the top.
// Depends on voxel_neighbourhood_generator only through its ports.
module vng_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // a result beat only ends a busy stretch
  a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) && !busy)
    else $error("result beat without a preceding busy cycle");

  // one beat per command, never two in a row
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // busy only rises on an accepted command
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

  // reset leaves the block idle with no beat pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind voxel_neighbourhood_generator vng_checker u_vng_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

// ----- verif/tb_voxel_neighbourhood_generator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for voxel_neighbourhood_generator: random begin/next command
// streams against a cycle-free predictor of the neighbour scan, over many level and size settings.
// Depends on vng_pkg and the RTL of the block only.
module tb_voxel_neighbourhood_generator;
  import vng_pkg::*;

  localparam int   CW          = COORD_BITS_DEF;
  localparam int   NUM_OFS     = 125;
  localparam int   IDLE_DRAIN  = 140;   // outlasts the longest command
  localparam int   STALL_LIMIT = 5000;
  localparam int   N_ITEMS     = 600;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          last;
  } nb_beat_t;

  // Tracks centre, cursor and registers; predicts each neighbour beat.
  class nb_scoreboard;
    logic [LEVEL_W-1:0] level  = LEVEL_RST;
    logic [SIZE_W-1:0]  size_x = SIZE_RST;
    logic [SIZE_W-1:0]  size_y = SIZE_RST;
    logic [SIZE_W-1:0]  size_z = SIZE_RST;
    logic [CW-1:0]      cx = '0;
    logic [CW-1:0]      cy = '0;
    logic [CW-1:0]      cz = '0;
    int                 cursor = NUM_OFS;
    bit                 active = 1'b0;
    nb_beat_t           expected_q[$];
    int                 n_errors  = 0;
    int                 n_checked = 0;

    function void write_reg(vng_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LEVEL:  level  = data[LEVEL_W-1:0];
        REG_SIZE_X: size_x = data;
        REG_SIZE_Y: size_y = data;
        REG_SIZE_Z: size_z = data;
        default: ;
      endcase
    endfunction

    function bit level_shape(output int range, output int limit);
      range = 0;
      limit = 0;
      case (level)
        7'd6:        begin range = 1; limit = 1; end
        7'd18:       begin range = 1; limit = 2; end
        7'd26, 7'd32: begin range = 1; limit = 3; end
        7'd56:       begin range = 2; limit = 3; end
        7'd92:       begin range = 2; limit = 4; end
        7'd116:      begin range = 2; limit = 5; end
        7'd124:      begin range = 2; limit = 6; end
        default:     return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function int mag(int v);
      return v < 0 ? -v : v;
    endfunction

    function bit axis_ok(int c, int d, int size);
      int p;
      p = c + d;
      return p >= 0 && p < size && p < (1 << CW);
    endfunction

    function bit offset_taken(int idx);
      int range, limit, dz, dy, dx, man;
      bit inc;
      if (!level_shape(range, limit)) return 1'b0;
      dz  = idx / 25 - 2;
      dy  = (idx / 5) % 5 - 2;
      dx  = idx % 5 - 2;
      man = mag(dz) + mag(dy) + mag(dx);
      inc = man != 0 && man <= limit && mag(dz) <= range && mag(dy) <= range &&
            mag(dx) <= range;
      // level 32 picks up the axis offsets at distance two
      if (level == 7'd32 && man == 2 && (mag(dz) == 2 || mag(dy) == 2 || mag(dx) == 2))
        inc = 1'b1;
      return inc && axis_ok(int'(cx), dx, int'(size_x)) &&
             axis_ok(int'(cy), dy, int'(size_y)) && axis_ok(int'(cz), dz, int'(size_z));
    endfunction

    function int scan_from(int first);
      for (int i = first; i < NUM_OFS; i++)
        if (offset_taken(i)) return i;
      return NUM_OFS;
    endfunction

    function void note_command(logic func, logic [CW-1:0] x, logic [CW-1:0] y,
                               logic [CW-1:0] z);
      int hit, after;
      nb_beat_t b;
      if (func == FUNC_BEGIN) begin
        cx = x;
        cy = y;
        cz = z;
        cursor = 0;
        active = 1'b1;
      end else if (!active) begin
        return;
      end
      hit = scan_from(cursor);
      if (hit >= NUM_OFS) begin
        cursor = NUM_OFS;
        active = 1'b0;
        return;
      end
      after  = scan_from(hit + 1);
      b.x    = CW'(int'(cx) + hit % 5 - 2);
      b.y    = CW'(int'(cy) + (hit / 5) % 5 - 2);
      b.z    = CW'(int'(cz) + hit / 25 - 2);
      b.last = after >= NUM_OFS;
      expected_q.insert(expected_q.size(), b);
      if (b.last) begin
        cursor = NUM_OFS;
        active = 1'b0;
      end else begin
        cursor = hit + 1;
      end
    endfunction

    function void cmp(string what, logic [CW-1:0] want, logic [CW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                               logic last);
      nb_beat_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual (%0d,%0d,%0d) last %0b",
                 $time, x, y, z, last);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      cmp("nb_x", want.x, x);
      cmp("nb_y", want.y, y);
      cmp("nb_z", want.z, z);
      cmp("last", CW'(want.last), CW'(last));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  vng_reg_t              cfg_index = REG_LEVEL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_func = FUNC_BEGIN;
  logic [CW-1:0]         in_centre_x = '0;
  logic [CW-1:0]         in_centre_y = '0;
  logic [CW-1:0]         in_centre_z = '0;
  logic                  out_valid;
  logic [CW-1:0]         out_nb_x;
  logic [CW-1:0]         out_nb_y;
  logic [CW-1:0]         out_nb_z;
  logic                  out_last;

  nb_scoreboard sb = new;
  int           n_items = 0;
  int           n_writes = 0;
  int           stall = 0;
  bit           idle_en = 1'b1;

  voxel_neighbourhood_generator #(.COORD_BITS(CW)) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_centre_x (in_centre_x),
    .in_centre_y (in_centre_y),
    .in_centre_z (in_centre_z),
    .out_valid   (out_valid),
    .out_nb_x    (out_nb_x),
    .out_nb_y    (out_nb_y),
    .out_nb_z    (out_nb_z),
    .out_last    (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result check, command capture and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_nb_x, out_nb_y, out_nb_z, out_last);
      if (start && !busy) sb.note_command(in_func, in_centre_x, in_centre_y, in_centre_z);
      if (out_valid || (start && !busy)) begin
        stall = 0;
      end else begin
        stall++;
      end
      if (stall >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [CW-1:0] rnd_coord();
    return CW'($urandom_range(0, (1 << CW) - 1));
  endfunction

  // favours the faces of the volume so that bounds drops are hit often
  function automatic logic [CW-1:0] pick_coord(int size);
    int v;
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 1;
      2:       v = size - 1;
      3:       v = size - 2;
      4:       v = size > 0 ? int'($urandom_range(0, size - 1)) : 0;
      default: v = int'(rnd_coord());
    endcase
    return CW'(v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 6;
      1:       v = 18;
      2:       v = 26;
      3:       v = 32;
      4:       v = 56;
      5:       v = 92;
      6:       v = 116;
      7:       v = 124;
      8:       v = $urandom_range(0, 127);
      default: v = $urandom_range(0, 2047);   // upper bits ignored
    endcase
    return CFG_DATA_W'(v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int v;
    case ($urandom_range(0, 15))
      0:          v = 0;
      1:          v = 2047;
      2:          v = 1024;
      3:          v = 1023;
      4, 5, 6:    v = $urandom_range(1, 6);
      7:          v = $urandom_range(1, 2047);
      default:    v = $urandom_range(3, 40);
    endcase
    return CFG_DATA_W'(v);
  endfunction

  // call at a falling edge with the block idle
  task automatic write_cfg(vng_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_cmd(logic func, logic [CW-1:0] x, logic [CW-1:0] y,
                          logic [CW-1:0] z);
    int gap;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    in_func     <= func;
    in_centre_x <= x;
    in_centre_y <= y;
    in_centre_z <= z;
    do @(posedge clk); while (busy);
    n_items++;
    @(negedge clk);
  endtask

  // next commands on the current centre; to_end runs to the last and one past it
  task automatic walk(int n, bit to_end);
    if (to_end) begin
      while (sb.active) send_cmd(FUNC_NEXT, rnd_coord(), rnd_coord(), rnd_coord());
      send_cmd(FUNC_NEXT, rnd_coord(), rnd_coord(), rnd_coord());
    end else begin
      repeat (n) send_cmd(FUNC_NEXT, rnd_coord(), rnd_coord(), rnd_coord());
    end
  endtask

  // let every expected beat arrive, then cover a silent command still running
  task automatic settle();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (IDLE_DRAIN) @(negedge clk);
  endtask

  initial begin
    int kind;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: next before any begin, corner centre at reset settings
    send_cmd(FUNC_NEXT, '1, '1, '1);
    send_cmd(FUNC_BEGIN, '0, '0, '0);
    walk(0, 1'b1);
    // unrecognised level
    settle();
    write_cfg(REG_LEVEL, '0);
    send_cmd(FUNC_BEGIN, CW'(5), CW'(5), CW'(5));
    send_cmd(FUNC_NEXT, '0, '0, '0);
    // level 32 at the top of the coordinate range, sizes beyond it
    settle();
    write_cfg(REG_LEVEL, CFG_DATA_W'(32));
    write_cfg(REG_SIZE_X, '1);
    write_cfg(REG_SIZE_Y, '1);
    write_cfg(REG_SIZE_Z, '1);
    send_cmd(FUNC_BEGIN, '1, '1, '1);
    walk(2, 1'b0);
    // zero extent along x: nothing in bounds
    settle();
    write_cfg(REG_LEVEL, CFG_DATA_W'(6));
    write_cfg(REG_SIZE_X, '0);
    send_cmd(FUNC_BEGIN, '0, '0, '0);
    // widest level in a tiny volume
    settle();
    write_cfg(REG_LEVEL, CFG_DATA_W'(124));
    write_cfg(REG_SIZE_X, CFG_DATA_W'(5));
    write_cfg(REG_SIZE_Y, CFG_DATA_W'(5));
    write_cfg(REG_SIZE_Z, CFG_DATA_W'(5));
    send_cmd(FUNC_BEGIN, '0, '0, '0);
    walk(3, 1'b0);

    while (n_items < N_ITEMS) begin
      settle();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1)) write_cfg(REG_LEVEL, pick_level());
        if ($urandom_range(0, 1)) write_cfg(REG_SIZE_X, pick_size());
        if ($urandom_range(0, 1)) write_cfg(REG_SIZE_Y, pick_size());
        if ($urandom_range(0, 1)) write_cfg(REG_SIZE_Z, pick_size());
      end
      idle_en = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(2, 5)) begin
        if (n_items >= N_ITEMS) break;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          repeat ($urandom_range(1, 6))
            send_cmd(1'($urandom_range(0, 1)), rnd_coord(), rnd_coord(), rnd_coord());
        end else if (kind == 1) begin
          walk($urandom_range(1, 8), 1'b0);   // old centre, possibly new settings
        end else begin
          send_cmd(FUNC_BEGIN, pick_coord(int'(sb.size_x)), pick_coord(int'(sb.size_y)),
                   pick_coord(int'(sb.size_z)));
          if (kind <= 3) begin
            walk(0, 1'b1);
          end else begin
            walk($urandom_range(0, 10), 1'b0);
          end
        end
      end
    end

    settle();
    $display("%0d commands accepted, %0d neighbour beats checked, %0d register writes",
             n_items, sb.n_checked, n_writes);
    $display("all levels incl. unknown ones, extents 0 to 2047, centres on volume faces");
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
